>>> sv/nnd_pkg.sv
// Package for the nearest-neighbor downscaler: size limits, derived widths,
// register map codes and the result item type.
// No dependencies; used by nearest_neighbor_downscaler.sv.
`timescale 1ns / 1ps
`default_nettype none

package nnd_pkg;

  // Largest source frame the block handles.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // Configuration register width and APB map.
  localparam int CFG_W   = 12;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 4;
  localparam int PIX_W   = 8;

  // Clamped sizes and output counters hold values up to the maximum itself.
  localparam int SW_W = $clog2(MAX_WIDTH + 1);
  localparam int SH_W = $clog2(MAX_HEIGHT + 1);
  // Source counters only reach the maximum minus one.
  localparam int SCOL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  // Running products never exceed source size times destination size.
  localparam int PW_W = $clog2(MAX_WIDTH * MAX_WIDTH + 1);
  localparam int PH_W = $clog2(MAX_HEIGHT * MAX_HEIGHT + 1);

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             row_end;
    logic             frame_end;
  } pix_t;

endpackage

`default_nettype wire

>>> sv/nearest_neighbor_downscaler.sv
// Channel  | Direction | Handshake           | Payload
// in_      | input     | in_valid/in_ready   | in_blue, in_green, in_red
// out_     | output    | out_valid/out_ready | out_blue/green/red, out_row_end, out_frame_end
// APB      | slave     | psel/penable/pready | paddr, pwdata, pwrite, prdata
//
// One source item is taken every cycle unless the skid entry is full; a picked pixel
// is registered into the output register, or into the skid entry while that is held.
// The pick decision is one add and compare on the running column and row products, so
// the rate is one item per clock while the skid entry is empty. A two-entry output buffer
// keeps the input flowing while one result waits. Reset is synchronous; any register
// write restarts the frame. Depends on nnd_pkg.sv.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_downscaler (
  input  wire                          clk,
  input  wire                          rst_n,
  // source pixels
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [nnd_pkg::PIX_W-1:0]    in_blue,
  input  wire  [nnd_pkg::PIX_W-1:0]    in_green,
  input  wire  [nnd_pkg::PIX_W-1:0]    in_red,
  // picked pixels
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [nnd_pkg::PIX_W-1:0]    out_blue,
  output logic [nnd_pkg::PIX_W-1:0]    out_green,
  output logic [nnd_pkg::PIX_W-1:0]    out_red,
  output logic                         out_row_end,
  output logic                         out_frame_end,
  // configuration
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [nnd_pkg::PADDR_W-1:0]  paddr,
  input  wire  [nnd_pkg::PDATA_W-1:0]  pwdata,
  output logic [nnd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int SW_W   = nnd_pkg::SW_W;
  localparam int SH_W   = nnd_pkg::SH_W;
  localparam int SCOL_W = nnd_pkg::SCOL_W;
  localparam int SROW_W = nnd_pkg::SROW_W;
  localparam int PW_W   = nnd_pkg::PW_W;
  localparam int PH_W   = nnd_pkg::PH_W;
  localparam int CFG_W  = nnd_pkg::CFG_W;

  // Configuration registers, stored as written.
  logic [CFG_W-1:0] src_width_r, src_height_r, dst_width_r, dst_height_r;

  // Frame position state.
  logic [SCOL_W-1:0] src_col_r, src_col_nxt;
  logic [SROW_W-1:0] src_row_r, src_row_nxt;
  logic [SW_W-1:0]   out_col_r, out_col_nxt;
  logic [SH_W-1:0]   out_row_r, out_row_nxt;
  logic [PW_W-1:0]   ctp_r, ctp_nxt, csp_r, csp_nxt;
  logic [PH_W-1:0]   rtp_r, rtp_nxt, rsp_r, rsp_nxt;

  // Output buffer: main register plus one skid entry.
  nnd_pkg::pix_t out_r, skid_r, pix_nxt;
  logic          out_valid_r, skid_valid_r;

  logic [SW_W-1:0] sw, dw;
  logic [SH_W-1:0] sh, dh;
  logic            cfg_wr, in_acc, out_pop, push;
  logic            col_hit, row_hit, col_last, row_last;
  nnd_pkg::reg_idx_t reg_idx;

  assign reg_idx = nnd_pkg::reg_idx_t'(paddr[nnd_pkg::PADDR_W-1:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      nnd_pkg::REG_SRC_WIDTH:  prdata = nnd_pkg::PDATA_W'(src_width_r);
      nnd_pkg::REG_SRC_HEIGHT: prdata = nnd_pkg::PDATA_W'(src_height_r);
      nnd_pkg::REG_DST_WIDTH:  prdata = nnd_pkg::PDATA_W'(dst_width_r);
      nnd_pkg::REG_DST_HEIGHT: prdata = nnd_pkg::PDATA_W'(dst_height_r);
      default:                 prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, the source is limited to the maximum,
  // and the destination never exceeds the source.
  always_comb begin
    if (src_width_r == '0) begin
      sw = SW_W'(1);
    end else if (32'(src_width_r) > 32'(nnd_pkg::MAX_WIDTH)) begin
      sw = SW_W'(nnd_pkg::MAX_WIDTH);
    end else begin
      sw = SW_W'(src_width_r);
    end
    if (src_height_r == '0) begin
      sh = SH_W'(1);
    end else if (32'(src_height_r) > 32'(nnd_pkg::MAX_HEIGHT)) begin
      sh = SH_W'(nnd_pkg::MAX_HEIGHT);
    end else begin
      sh = SH_W'(src_height_r);
    end
    if (dst_width_r == '0) begin
      dw = SW_W'(1);
    end else if (32'(dst_width_r) > 32'(sw)) begin
      dw = sw;
    end else begin
      dw = SW_W'(dst_width_r);
    end
    if (dst_height_r == '0) begin
      dh = SH_W'(1);
    end else if (32'(dst_height_r) > 32'(sh)) begin
      dh = sh;
    end else begin
      dh = SH_W'(dst_height_r);
    end
  end

  assign in_ready = !skid_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign out_pop  = out_valid_r && out_ready;

  // A column is picked while its scaled target still lies below the end of
  // the current source column; the row test works the same way.
  assign col_hit  = (out_col_r < dw) && (ctp_r < csp_r + PW_W'(dw));
  assign row_hit  = (out_row_r < dh) && (rtp_r < rsp_r + PH_W'(dh));
  assign col_last = 32'(src_col_r) >= 32'(sw) - 32'd1;
  assign row_last = 32'(src_row_r) >= 32'(sh) - 32'd1;
  assign push     = in_acc && col_hit && row_hit;

  always_comb begin
    pix_nxt.blue      = in_blue;
    pix_nxt.green     = in_green;
    pix_nxt.red       = in_red;
    pix_nxt.row_end   = (out_col_r == dw - SW_W'(1));
    pix_nxt.frame_end = pix_nxt.row_end && (out_row_r == dh - SH_W'(1));
  end

  always_comb begin
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    ctp_nxt     = ctp_r;
    csp_nxt     = csp_r;
    rtp_nxt     = rtp_r;
    rsp_nxt     = rsp_r;
    if (cfg_wr) begin
      src_col_nxt = '0;
      src_row_nxt = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      ctp_nxt     = '0;
      csp_nxt     = '0;
      rtp_nxt     = '0;
      rsp_nxt     = '0;
    end else if (in_acc) begin
      if (col_hit) begin
        out_col_nxt = out_col_r + SW_W'(1);
        ctp_nxt     = ctp_r + PW_W'(sw);
      end
      if (col_last) begin
        src_col_nxt = '0;
        csp_nxt     = '0;
        out_col_nxt = '0;
        ctp_nxt     = '0;
        if (row_hit) begin
          out_row_nxt = out_row_r + SH_W'(1);
          rtp_nxt     = rtp_r + PH_W'(sh);
        end
        if (row_last) begin
          src_row_nxt = '0;
          rsp_nxt     = '0;
          out_row_nxt = '0;
          rtp_nxt     = '0;
        end else begin
          src_row_nxt = src_row_r + SROW_W'(1);
          rsp_nxt     = rsp_r + PH_W'(dh);
        end
      end else begin
        src_col_nxt = src_col_r + SCOL_W'(1);
        csp_nxt     = csp_r + PW_W'(dw);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= CFG_W'(64);
      src_height_r <= CFG_W'(32);
      dst_width_r  <= CFG_W'(64);
      dst_height_r <= CFG_W'(32);
      src_col_r    <= '0;
      src_row_r    <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      ctp_r        <= '0;
      csp_r        <= '0;
      rtp_r        <= '0;
      rsp_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          nnd_pkg::REG_SRC_WIDTH:  src_width_r  <= pwdata[CFG_W-1:0];
          nnd_pkg::REG_SRC_HEIGHT: src_height_r <= pwdata[CFG_W-1:0];
          nnd_pkg::REG_DST_WIDTH:  dst_width_r  <= pwdata[CFG_W-1:0];
          nnd_pkg::REG_DST_HEIGHT: dst_height_r <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      ctp_r     <= ctp_nxt;
      csp_r     <= csp_nxt;
      rtp_r     <= rtp_nxt;
      rsp_r     <= rsp_nxt;

      // While the skid entry is full no item is accepted, so only a pop moves it.
      if (skid_valid_r) begin
        if (out_pop) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid_r || out_pop) begin
          out_r       <= pix_nxt;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= pix_nxt;
          skid_valid_r <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_blue      = out_r.blue;
  assign out_green     = out_r.green;
  assign out_red       = out_r.red;
  assign out_row_end   = out_r.row_end;
  assign out_frame_end = out_r.frame_end;

  // The skid entry only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds an item while the output register is empty");

  // The output column counter never runs past the destination width.
  a_out_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_col_r <= dw)
    else $error("output column counter beyond destination width");

  // A register write puts the frame back at its first pixel.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (src_col_r == '0 && src_row_r == '0 && out_row_r == '0))
    else $error("frame not restarted after a register write");

  // The last pixel of the frame is also the last of its row.
  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.frame_end) |-> out_r.row_end)
    else $error("frame end flagged without row end");

endmodule

`default_nettype wire
